### design/klc_pkg.sv
// klc_pkg: request types, status codes, key codes and register indexes
// for the keypad code lock; has no dependencies
package klc_pkg;

  // one keypad poll
  typedef struct packed {
    logic [1:0] key_code;
    logic       second_pulse;
  } in_req_t;

  // one poll result
  typedef struct packed {
    logic [2:0] status;
    logic [2:0] digits_entered;
    logic [1:0] tries_left;
    logic [7:0] lockout_left;
    logic       cursor_visible;
    logic       session_end;
  } out_req_t;

  // configuration register set
  typedef struct packed {
    logic [3:0]  stored_code;
    logic [15:0] timeout_polls;
    logic [7:0]  lockout_seconds;
    logic [1:0]  tries_allowed;
    logic [9:0]  blink_half_polls;
  } cfg_t;

  // status codes
  localparam logic [2:0] ST_WAITING  = 3'd0;
  localparam logic [2:0] ST_DIGIT    = 3'd1;
  localparam logic [2:0] ST_GRANTED  = 3'd2;
  localparam logic [2:0] ST_WRONG    = 3'd3;
  localparam logic [2:0] ST_LOCKED   = 3'd4;
  localparam logic [2:0] ST_UNLOCKED = 3'd5;
  localparam logic [2:0] ST_TIMEOUT  = 3'd6;

  // key codes
  localparam logic [1:0] KEY_NONE = 2'd0;
  localparam logic [1:0] KEY_ZERO = 2'd1;
  localparam logic [1:0] KEY_ONE  = 2'd2;

  // register indexes
  localparam logic [2:0] REG_STORED_CODE  = 3'd0;
  localparam logic [2:0] REG_TIMEOUT      = 3'd1;
  localparam logic [2:0] REG_LOCKOUT      = 3'd2;
  localparam logic [2:0] REG_TRIES        = 3'd3;
  localparam logic [2:0] REG_BLINK_HALF   = 3'd4;

  // register reset values
  localparam logic [3:0]  RST_STORED_CODE = 4'd0;
  localparam logic [15:0] RST_TIMEOUT     = 16'd10000;
  localparam logic [7:0]  RST_LOCKOUT     = 8'd180;
  localparam logic [1:0]  RST_TRIES       = 2'd3;
  localparam logic [9:0]  RST_BLINK_HALF  = 10'd500;

endpackage

### design/klc_cfg_regs.sv
// klc_cfg_regs: configuration register file of the keypad code lock
// depends on klc_pkg
module klc_cfg_regs (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  logic [2:0]    cfg_index,
  input  logic [15:0]   cfg_wdata,
  output klc_pkg::cfg_t cfg
);
  import klc_pkg::*;

  cfg_t cfg_r;

  // register writes, unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.stored_code      <= RST_STORED_CODE;
      cfg_r.timeout_polls    <= RST_TIMEOUT;
      cfg_r.lockout_seconds  <= RST_LOCKOUT;
      cfg_r.tries_allowed    <= RST_TRIES;
      cfg_r.blink_half_polls <= RST_BLINK_HALF;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_STORED_CODE: cfg_r.stored_code      <= cfg_wdata[3:0];
        REG_TIMEOUT:     cfg_r.timeout_polls    <= cfg_wdata;
        REG_LOCKOUT:     cfg_r.lockout_seconds  <= cfg_wdata[7:0];
        REG_TRIES:       cfg_r.tries_allowed    <= cfg_wdata[1:0];
        REG_BLINK_HALF:  cfg_r.blink_half_polls <= cfg_wdata[9:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

### design/klc_step.sv
// klc_step: lock state registers and the per-poll update logic
// depends on klc_pkg
module klc_step #(
  parameter int CODE_DIGITS = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step_en,
  input  klc_pkg::in_req_t  req,
  input  klc_pkg::cfg_t     cfg,
  output klc_pkg::out_req_t rsp
);
  import klc_pkg::*;

  localparam int CW = $clog2(CODE_DIGITS + 1);
  localparam logic [CW-1:0] DIGITS_FULL = CW'(CODE_DIGITS);

  logic                   locked_r,   locked_nxt;
  logic [CW-1:0]          dcnt_r,     dcnt_nxt;
  logic [CODE_DIGITS-1:0] bits_r,     bits_nxt;
  logic [1:0]             tries_r,    tries_nxt;
  logic [7:0]             lock_cnt_r, lock_cnt_nxt;
  logic [15:0]            polls_r,    polls_nxt;
  logic [10:0]            phase_r,    phase_nxt;

  logic [CODE_DIGITS-1:0] code_ext;
  logic [CODE_DIGITS-1:0] bits_key;
  logic [CW-1:0]          dcnt_key;
  logic [10:0]            phase_inc;
  logic [7:0]             lock_dec;
  logic                   key_digit;
  logic [2:0]             status;
  logic                   cursor;
  logic                   sess_end;

  // stored code widened or cut to the code length, upper digits are zero
  always_comb begin
    for (int i = 0; i < CODE_DIGITS; i++) begin
      code_ext[i] = (i < 4) ? cfg.stored_code[i % 4] : 1'b0;
    end
  end

  // digit shifted in at the current position
  always_comb begin
    bits_key = bits_r;
    for (int i = 0; i < CODE_DIGITS; i++) begin
      if (dcnt_r == CW'(i) && req.key_code == KEY_ONE) begin
        bits_key[i] = 1'b1;
      end
    end
    dcnt_key = dcnt_r + CW'(1);
  end

  assign key_digit = (req.key_code == KEY_ZERO || req.key_code == KEY_ONE) &&
                     (dcnt_r < DIGITS_FULL);
  assign phase_inc = phase_r + 11'd1;
  assign lock_dec  = (req.second_pulse && lock_cnt_r != 8'd0) ? lock_cnt_r - 8'd1
                                                              : lock_cnt_r;

  // next state and result of one poll
  always_comb begin
    locked_nxt   = locked_r;
    dcnt_nxt     = dcnt_r;
    bits_nxt     = bits_r;
    tries_nxt    = tries_r;
    lock_cnt_nxt = lock_cnt_r;
    polls_nxt    = polls_r;
    phase_nxt    = phase_r;
    status       = ST_WAITING;
    cursor       = 1'b0;
    sess_end     = 1'b0;
    if (locked_r) begin
      // lockout countdown
      lock_cnt_nxt = lock_dec;
      if (lock_dec == 8'd0) begin
        locked_nxt = 1'b0;
        tries_nxt  = cfg.tries_allowed;
        dcnt_nxt   = '0;
        bits_nxt   = '0;
        status     = ST_UNLOCKED;
      end else begin
        status = ST_LOCKED;
      end
    end else if (polls_r == cfg.timeout_polls) begin
      // session timeout
      dcnt_nxt  = '0;
      bits_nxt  = '0;
      tries_nxt = cfg.tries_allowed;
      polls_nxt = '0;
      phase_nxt = '0;
      status    = ST_TIMEOUT;
      sess_end  = 1'b1;
    end else if (tries_r == 2'd0) begin
      // lockout start, key discarded
      locked_nxt   = 1'b1;
      lock_cnt_nxt = cfg.lockout_seconds;
      dcnt_nxt     = '0;
      bits_nxt     = '0;
      status       = ST_LOCKED;
    end else begin
      // entry poll: cursor, then key, then compare
      polls_nxt = polls_r + 16'd1;
      cursor    = (phase_r < {1'b0, cfg.blink_half_polls});
      phase_nxt = (phase_inc >= {cfg.blink_half_polls, 1'b0}) ? 11'd0 : phase_inc;
      if (key_digit) begin
        dcnt_nxt = dcnt_key;
        bits_nxt = bits_key;
        status   = ST_DIGIT;
      end
      if (dcnt_nxt >= DIGITS_FULL) begin
        if (bits_nxt == code_ext) begin
          dcnt_nxt  = '0;
          bits_nxt  = '0;
          tries_nxt = cfg.tries_allowed;
          polls_nxt = '0;
          phase_nxt = '0;
          status    = ST_GRANTED;
          sess_end  = 1'b1;
        end else begin
          dcnt_nxt  = '0;
          bits_nxt  = '0;
          tries_nxt = tries_r - 2'd1;
          status    = ST_WRONG;
        end
      end
    end
  end

  // result fields
  always_comb begin
    rsp.status         = status;
    rsp.digits_entered = 3'(dcnt_nxt);
    rsp.tries_left     = tries_nxt;
    rsp.lockout_left   = locked_nxt ? lock_cnt_nxt : 8'd0;
    rsp.cursor_visible = cursor;
    rsp.session_end    = sess_end;
  end

  // state registers, updated once per poll
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      locked_r   <= 1'b0;
      dcnt_r     <= '0;
      bits_r     <= '0;
      tries_r    <= RST_TRIES;
      lock_cnt_r <= 8'd0;
      polls_r    <= 16'd0;
      phase_r    <= 11'd0;
    end else if (step_en) begin
      locked_r   <= locked_nxt;
      dcnt_r     <= dcnt_nxt;
      bits_r     <= bits_nxt;
      tries_r    <= tries_nxt;
      lock_cnt_r <= lock_cnt_nxt;
      polls_r    <= polls_nxt;
      phase_r    <= phase_nxt;
    end
  end

endmodule

### design/keypad_code_lock.sv
// keypad_code_lock: top level, input and result registers around the lock
// depends on klc_pkg, klc_cfg_regs and klc_step
//
// Usage: each request on the in_ channel is one keypad poll (key code and
// one-second pulse); each poll yields exactly one result request on the
// out_ channel carrying status, digit count, tries, lockout time, cursor
// and session end. Configuration is written through cfg_we/cfg_index/
// cfg_wdata while no poll is in flight; it takes effect on the next poll.
// A poll is captured in the input register, processed by klc_step and its
// result is then captured in the result register.
// Throughput: one poll per cycle while the receiver does not stall; the state
// update loop of klc_step sets this figure.
// Reset (rst_n low, synchronous) returns registers to their defaults and
// the lock to entry mode with all tries available; no result is pending.
// When the receiver stalls, the result register holds; an empty input
// register takes one more poll, and in_stall is raised until the result moves.
module keypad_code_lock #(
  parameter int CODE_DIGITS = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  klc_pkg::in_req_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output klc_pkg::out_req_t out_data,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [15:0]       cfg_wdata
);
  import klc_pkg::*;

  cfg_t     cfg;
  in_req_t  in_data_r;
  logic     in_vld_r;
  out_req_t out_data_r;
  logic     out_vld_r;
  out_req_t step_rsp;
  logic     advance;
  logic     step_en;

  klc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  klc_step #(
    .CODE_DIGITS (CODE_DIGITS)
  ) u_step (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .req     (in_data_r),
    .cfg     (cfg),
    .rsp     (step_rsp)
  );

  // handshake control
  assign advance  = !out_vld_r || !out_stall;
  assign step_en  = in_vld_r && advance;
  assign in_stall = in_vld_r && !advance;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_data_r <= in_data;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      out_data_r <= step_rsp;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

endmodule
